// ----- design/pc_pkg.sv -----
// Shared types and constants for the polygon centroid block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pc_pkg;

   // Defaults for the top-level parameters
   localparam int DEFAULT_MAX_VERTICES = 64;
   localparam int DEFAULT_COORD_WIDTH  = 16;

   // Accumulators and the divider operate modulo 2^64
   localparam int ACC_WIDTH = 64;

   // Result status codes
   localparam int STATUS_WIDTH = 2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FEW_VERTS = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO_AREA = 2'd2;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } pc_div_status_type;

endpackage : pc_pkg

`default_nettype wire

// ----- design/pc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on pc_pkg; instantiated by polygon_centroid.
`timescale 1ns / 1ps
`default_nettype none

module pc_mul import pc_pkg::*; #(
   parameter int A_WIDTH = 2 * DEFAULT_COORD_WIDTH + 3,
   parameter int B_WIDTH = DEFAULT_COORD_WIDTH + 2
) (
   input  logic                                clock,
   input  logic signed [A_WIDTH-1:0]           a,
   input  logic signed [B_WIDTH-1:0]           b,
   output logic signed [A_WIDTH+B_WIDTH-1:0]   product
);

   logic signed [A_WIDTH+B_WIDTH-1:0] product_ff;
   logic signed [A_WIDTH+B_WIDTH-1:0] product_in;

   // Form the full-width signed product
   always_comb begin
      product_in = a * b;
   end

   // Register the product for the next sequencer step
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule : pc_mul

`default_nettype wire

// ----- design/pc_div.sv -----
// Iterative restoring divider: one quotient bit a cycle, then rounding to nearest
// (ties away from zero) and saturation to the signed coordinate range.
// Depends on pc_pkg; instantiated by polygon_centroid.
`timescale 1ns / 1ps
`default_nettype none

module pc_div import pc_pkg::*; #(
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ACC_WIDTH-1:0]          num,
   input  logic [ACC_WIDTH-1:0]          den,
   output pc_div_status_type             status,
   output logic signed [COORD_WIDTH-1:0] quot
);

   localparam int CNT_WIDTH = $clog2(ACC_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(ACC_WIDTH - 1);
   localparam logic [ACC_WIDTH-1:0] SAT_NEG  = ACC_WIDTH'(1) << (COORD_WIDTH - 1);
   localparam logic [ACC_WIDTH-1:0] SAT_POS  = SAT_NEG - ACC_WIDTH'(1);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_ROUND
   } div_state_type;

   div_state_type           state_ff, state_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    nneg_ff, nneg_in;
   logic                    dneg_ff, dneg_in;
   logic [ACC_WIDTH-1:0]    dm_ff, dm_in;
   logic [ACC_WIDTH-1:0]    q_ff, q_in;
   logic [ACC_WIDTH-1:0]    rem_ff, rem_in;
   logic                    done_ff, done_in;
   logic [COORD_WIDTH-1:0]  quot_ff, quot_in;

   logic [ACC_WIDTH:0]      rem_shift;
   logic [ACC_WIDTH:0]      trial;
   logic                    round_up;
   logic [ACC_WIDTH-1:0]    q_round;
   logic [ACC_WIDTH-1:0]    q_sat;
   logic [ACC_WIDTH-1:0]    q_neg;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      rem_shift = {rem_ff, q_ff[ACC_WIDTH-1]};
      trial     = rem_shift - {1'b0, dm_ff};
   end

   // Round on twice the remainder, then clamp the magnitude
   always_comb begin
      round_up = ({rem_ff, 1'b0} >= {1'b0, dm_ff});
      q_round  = q_ff + ACC_WIDTH'(round_up);
      if (nneg_ff != dneg_ff) begin
         q_sat = (q_round > SAT_NEG) ? SAT_NEG : q_round;
      end else begin
         q_sat = (q_round > SAT_POS) ? SAT_POS : q_round;
      end
      q_neg = ACC_WIDTH'(0) - q_sat;
   end

   // Sequence the divide
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      nneg_in  = nneg_ff;
      dneg_in  = dneg_ff;
      dm_in    = dm_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               nneg_in  = num[ACC_WIDTH-1];
               dneg_in  = den[ACC_WIDTH-1];
               q_in     = num[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - num) : num;
               dm_in    = den[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - den) : den;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (!trial[ACC_WIDTH]) begin
               rem_in = trial[ACC_WIDTH-1:0];
            end else begin
               rem_in = rem_shift[ACC_WIDTH-1:0];
            end
            q_in   = {q_ff[ACC_WIDTH-2:0], ~trial[ACC_WIDTH]};
            cnt_in = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == LAST_BIT) begin
               state_in = D_ROUND;
            end
         end
         D_ROUND: begin
            if (nneg_ff != dneg_ff) begin
               quot_in = q_neg[COORD_WIDTH-1:0];
            end else begin
               quot_in = q_sat[COORD_WIDTH-1:0];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   // Hold divider state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      dm_ff   <= dm_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.busy = (state_ff != D_IDLE);
   assign status.done = done_ff;
   assign quot        = quot_ff;

endmodule : pc_div

`default_nettype wire

// ----- design/polygon_centroid.sv -----
// Top level of the polygon centroid block: vertex sequencer and accumulators.
// Depends on pc_pkg, pc_mul and pc_div.
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid/req_stall  | vertex_x, vertex_y, last_vertex
//   rsp_    | out       | rsp_valid/rsp_stall  | centroid_x, centroid_y, status
//
// The first two vertices are only stored; for every later vertex the
// cross product and two weighted sums take turns on the one shared multiplier.
// A closing vertex adds a check, two divides and a hand-off, or only the check
// and hand-off when only a status is reported. Reset is synchronous, active
// high, and clears the sums and vertex count. A result waiting on rsp_stall holds
// only a second finished polygon in the output step; vertex words stall while it waits.
`timescale 1ns / 1ps
`default_nettype none

module polygon_centroid import pc_pkg::*; #(
   parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES,
   parameter int COORD_WIDTH  = DEFAULT_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_centroid_x,
   output logic signed [COORD_WIDTH-1:0] rsp_centroid_y,
   output logic [STATUS_WIDTH-1:0]       rsp_status
);

   localparam int DW   = COORD_WIDTH + 1;      // offset from the first vertex
   localparam int SW   = COORD_WIDTH + 2;      // sum of three coordinates
   localparam int CRW  = 2 * COORD_WIDTH + 3;  // cross product
   localparam int PW   = CRW + SW;             // multiplier product
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_VERTICES);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_CROSS,
      S_WX,
      S_WY,
      S_ACC_Y,
      S_CHECK,
      S_DIV_X,
      S_DIV_Y,
      S_OUT
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_x_in;
   logic signed [COORD_WIDTH-1:0] first_y_ff, first_y_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic signed [DW-1:0]          prev_dx_ff, prev_dx_in;
   logic signed [DW-1:0]          prev_dy_ff, prev_dy_in;
   logic signed [DW-1:0]          cur_dx_ff, cur_dx_in;
   logic signed [DW-1:0]          cur_dy_ff, cur_dy_in;
   logic signed [SW-1:0]          sx3_ff, sx3_in;
   logic signed [SW-1:0]          sy3_ff, sy3_in;
   logic [CNTW-1:0]               count_ff, count_in;
   logic                          last_ff, last_in;
   logic signed [CRW-1:0]         p1_ff, p1_in;
   logic signed [CRW-1:0]         cross_ff, cross_in;
   logic [ACC_WIDTH-1:0]          cross_sum_ff, cross_sum_in;
   logic [ACC_WIDTH-1:0]          wx_sum_ff, wx_sum_in;
   logic [ACC_WIDTH-1:0]          wy_sum_ff, wy_sum_in;
   logic signed [COORD_WIDTH-1:0] res_x_ff, res_x_in;
   logic signed [COORD_WIDTH-1:0] res_y_ff, res_y_in;
   logic [STATUS_WIDTH-1:0]       res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_WIDTH-1:0] rsp_y_ff, rsp_y_in;
   logic [STATUS_WIDTH-1:0]       rsp_status_ff, rsp_status_in;

   logic                          req_accept;
   logic                          rsp_free;
   logic signed [DW-1:0]          dx_new;
   logic signed [DW-1:0]          dy_new;
   logic signed [SW-1:0]          sx3_new;
   logic signed [SW-1:0]          sy3_new;
   logic signed [CRW-1:0]         mul_a;
   logic signed [SW-1:0]          mul_b;
   logic signed [PW-1:0]          mul_p;
   logic                          div_start;
   logic [ACC_WIDTH-1:0]          div_num;
   logic [ACC_WIDTH-1:0]          div_den;
   pc_div_status_type             div_stat;
   logic signed [COORD_WIDTH-1:0] div_quot;

   pc_mul #(
      .A_WIDTH (CRW),
      .B_WIDTH (SW)
   ) u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p)
   );

   pc_div #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_stat),
      .quot   (div_quot)
   );

   // Take a vertex word only between vertices
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Offsets from the first vertex and the fan triangle's coordinate sums
   always_comb begin
      dx_new  = DW'(req_vertex_x) - DW'(first_x_ff);
      dy_new  = DW'(req_vertex_y) - DW'(first_y_ff);
      sx3_new = SW'(first_x_ff) + SW'(prev_x_ff) + SW'(req_vertex_x);
      sy3_new = SW'(first_y_ff) + SW'(prev_y_ff) + SW'(req_vertex_y);
   end

   // Steer the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_A: begin
            mul_a = CRW'(prev_dx_ff);
            mul_b = SW'(cur_dy_ff);
         end
         S_MUL_B: begin
            mul_a = CRW'(prev_dy_ff);
            mul_b = SW'(cur_dx_ff);
         end
         S_WX: begin
            mul_a = cross_ff;
            mul_b = sx3_ff;
         end
         S_WY: begin
            mul_a = cross_ff;
            mul_b = sy3_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divide x first, then y, by three times the cross sum
   always_comb begin
      div_den   = (cross_sum_ff << 1) + cross_sum_ff;
      div_num   = (state_ff == S_DIV_X) ? wy_sum_ff : wx_sum_ff;
      div_start = 1'b0;
      if (state_ff == S_CHECK) begin
         div_start = (count_ff >= CNTW'(3)) && (cross_sum_ff != '0);
      end else if (state_ff == S_DIV_X) begin
         div_start = div_stat.done;
      end
   end

   // Sequence vertices and the final divide
   always_comb begin
      state_in      = state_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_dx_in    = prev_dx_ff;
      prev_dy_in    = prev_dy_ff;
      cur_dx_in     = cur_dx_ff;
      cur_dy_in     = cur_dy_ff;
      sx3_in        = sx3_ff;
      sy3_in        = sy3_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      p1_in         = p1_ff;
      cross_in      = cross_ff;
      cross_sum_in  = cross_sum_ff;
      wx_sum_in     = wx_sum_ff;
      wy_sum_in     = wy_sum_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               last_in  = req_last_vertex;
               state_in = req_last_vertex ? S_CHECK : S_IDLE;
               if (count_ff < CNT_MAX) begin
                  count_in  = count_ff + CNTW'(1);
                  prev_x_in = req_vertex_x;
                  prev_y_in = req_vertex_y;
                  if (count_ff == '0) begin
                     first_x_in = req_vertex_x;
                     first_y_in = req_vertex_y;
                  end else if (count_ff == CNTW'(1)) begin
                     prev_dx_in = dx_new;
                     prev_dy_in = dy_new;
                  end else begin
                     cur_dx_in = dx_new;
                     cur_dy_in = dy_new;
                     sx3_in    = sx3_new;
                     sy3_in    = sy3_new;
                     state_in  = S_MUL_A;
                  end
               end
            end
         end
         S_MUL_A: begin
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            p1_in    = CRW'(mul_p);
            state_in = S_CROSS;
         end
         S_CROSS: begin
            cross_in = p1_ff - CRW'(mul_p);
            state_in = S_WX;
         end
         S_WX: begin
            cross_sum_in = cross_sum_ff + ACC_WIDTH'(cross_ff);
            state_in     = S_WY;
         end
         S_WY: begin
            wx_sum_in  = wx_sum_ff + ACC_WIDTH'(mul_p);
            prev_dx_in = cur_dx_ff;
            prev_dy_in = cur_dy_ff;
            state_in   = S_ACC_Y;
         end
         S_ACC_Y: begin
            wy_sum_in = wy_sum_ff + ACC_WIDTH'(mul_p);
            state_in  = last_ff ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            res_x_in = '0;
            res_y_in = '0;
            if (count_ff < CNTW'(3)) begin
               res_status_in = STATUS_FEW_VERTS;
               state_in      = S_OUT;
            end else if (cross_sum_ff == '0) begin
               res_status_in = STATUS_ZERO_AREA;
               state_in      = S_OUT;
            end else begin
               res_status_in = STATUS_OK;
               state_in      = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (div_stat.done) begin
               res_x_in = div_quot;
               state_in = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_stat.done) begin
               res_y_in = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Move the result to the output slot and drop the polygon
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_status_in = res_status_ff;
               count_in      = '0;
               cross_sum_in  = '0;
               wx_sum_in     = '0;
               wy_sum_in     = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold sequencer state, sums and the output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cross_sum_ff <= '0;
         wx_sum_ff    <= '0;
         wy_sum_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cross_sum_ff <= cross_sum_in;
         wx_sum_ff    <= wx_sum_in;
         wy_sum_ff    <= wy_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_x_ff    <= first_x_in;
      first_y_ff    <= first_y_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      prev_dx_ff    <= prev_dx_in;
      prev_dy_ff    <= prev_dy_in;
      cur_dx_ff     <= cur_dx_in;
      cur_dy_ff     <= cur_dy_in;
      sx3_ff        <= sx3_in;
      sy3_ff        <= sy3_in;
      last_ff       <= last_in;
      p1_ff         <= p1_in;
      cross_ff      <= cross_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_status_ff <= res_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_centroid_x = rsp_x_ff;
   assign rsp_centroid_y = rsp_y_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   // Vertex count never passes the polygon limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("vertex count beyond limit");

   // A divide starts only on an idle divider
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divide started while divider busy");

   // Divider results arrive only while the sequencer waits on them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV_X || state_ff == S_DIV_Y))
      else $error("divider result with no divide pending");

   // Delivering a result leaves the polygon state cleared
   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_free) |=>
         (rsp_valid_ff && count_ff == '0 && cross_sum_ff == '0))
      else $error("polygon state not cleared after result");
`endif

endmodule : polygon_centroid

`default_nettype wire
